[rtl/pid_steering_drive_macros.svh]
// ----------------------------------------------------------------------------
// pid steering drive assertion macros
// shared property forms for the steering drive checks
// ----------------------------------------------------------------------------
`ifndef PID_STEERING_DRIVE_MACROS_SVH
`define PID_STEERING_DRIVE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psd check failed");

// next-cycle implication, disabled in reset
`define PSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psd check failed");

`endif

[rtl/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// word types and constants of the steering drive pid controller
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] position;
    } in_word_t;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              steer_left;
        logic [13:0]       duty_count;
    } out_word_t;

    typedef enum logic [1:0] {
        CFG_GAIN_P   = 2'd0,
        CFG_GAIN_I   = 2'd1,
        CFG_GAIN_D   = 2'd2,
        CFG_OUT_LIM  = 2'd3
    } cfg_index_t;

    localparam logic [23:0] GAIN_P_RESET   = 24'd275251;
    localparam logic [23:0] GAIN_I_RESET   = 24'd33;
    localparam logic [23:0] GAIN_D_RESET   = 24'd32768;
    localparam logic [6:0]  OUT_LIM_RESET  = 7'd99;
    localparam logic [6:0]  DRIVE_CAP      = 7'd99;
    localparam logic [13:0] DUTY_TOP       = 14'd15900;

endpackage

`default_nettype wire

[rtl/pid_steering_drive.sv]
// ----------------------------------------------------------------------------
// pid_steering_drive
// discrete position-form pid controller for a steering drive
// ----------------------------------------------------------------------------
// Takes one word per cycle when not stalled. Three register stages (error and
// integral, gain products, sum/clamp result) carry each accepted word through
// s1, s2 and the output register; a stalled output holds the pipeline and the
// input stalls once all three stages are full. The integral and previous error
// update at acceptance, so words may follow back to back. The user must write
// gains and the limit through cfg_we/cfg_index/cfg_data only while no word is
// in flight; the block itself does not enforce it.
`default_nettype none

`include "pid_steering_drive_macros.svh"

module pid_steering_drive
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire psd_pkg::in_word_t in_word,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output psd_pkg::out_word_t    out_word,

    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [23:0]      cfg_data
);

    // configuration
    logic [23:0] gain_p_reg;
    logic [23:0] gain_i_reg;
    logic [23:0] gain_d_reg;
    logic [6:0]  out_lim_reg;

    // controller state
    logic signed [31:0] error_sum_reg;
    logic signed [31:0] error_sum_next;
    logic signed [16:0] prev_error_reg;

    // stage 1
    logic               s1_valid_reg;
    logic signed [16:0] s1_err_reg;
    logic signed [31:0] s1_sum_reg;
    logic signed [17:0] s1_deriv_reg;

    // stage 2
    logic               s2_valid_reg;
    logic signed [41:0] s2_p_reg;
    logic signed [56:0] s2_i_reg;
    logic signed [42:0] s2_d_reg;

    // output
    logic               out_valid_reg;
    psd_pkg::out_word_t out_word_reg;
    psd_pkg::out_word_t out_word_next;

    // handshake
    logic ready_out;
    logic ready2;
    logic ready1;
    logic accept;
    logic adv2;
    logic adv3;

    // front end arithmetic
    logic signed [16:0] err;
    logic signed [32:0] acc;
    logic signed [17:0] deriv;

    // back end arithmetic
    logic signed [24:0] gain_p_s;
    logic signed [24:0] gain_i_s;
    logic signed [24:0] gain_d_s;
    logic signed [41:0] p_next;
    logic signed [56:0] i_next;
    logic signed [42:0] d_next;
    logic signed [57:0] sum;
    logic signed [57:0] sum_biased;
    logic signed [41:0] quot;
    logic [6:0]         lim;
    logic signed [41:0] lim_pos;
    logic signed [41:0] lim_neg;
    logic signed [7:0]  drive;
    logic [6:0]         mag;
    logic [13:0]        scaled;

    assign ready_out = !out_valid_reg || !out_stall;
    assign ready2    = !s2_valid_reg || ready_out;
    assign ready1    = !s1_valid_reg || ready2;
    assign accept    = in_valid && ready1;
    assign adv2      = s1_valid_reg && ready2;
    assign adv3      = s2_valid_reg && ready_out;
    assign in_stall  = !ready1;

    // error, saturating integral, derivative
    always_comb
    begin
        err   = 17'({in_word.target[15], in_word.target})
              - 17'({in_word.position[15], in_word.position});
        acc   = 33'({error_sum_reg[31], error_sum_reg}) + 33'({{16{err[16]}}, err});
        deriv = 18'({err[16], err}) - 18'({prev_error_reg[16], prev_error_reg});
        if (acc[32] != acc[31])
        begin
            error_sum_next = acc[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            error_sum_next = acc[31:0];
        end
    end

    // gain products
    always_comb
    begin
        gain_p_s = {1'b0, gain_p_reg};
        gain_i_s = {1'b0, gain_i_reg};
        gain_d_s = {1'b0, gain_d_reg};
        p_next   = gain_p_s * s1_err_reg;
        i_next   = gain_i_s * s1_sum_reg;
        d_next   = gain_d_s * s1_deriv_reg;
    end

    // sum, truncate toward zero, clamp, duty
    always_comb
    begin
        sum        = 58'(s2_p_reg) + 58'(s2_i_reg) + 58'(s2_d_reg);
        sum_biased = sum + (sum[57] ? 58'sd65535 : 58'sd0);
        quot       = sum_biased[57:16];
        lim        = (out_lim_reg > psd_pkg::DRIVE_CAP) ? psd_pkg::DRIVE_CAP : out_lim_reg;
        lim_pos    = {35'd0, lim};
        lim_neg    = -lim_pos;
        if (quot > lim_pos)
        begin
            drive = {1'b0, lim};
        end
        else if (quot < lim_neg)
        begin
            drive = 8'(lim_neg);
        end
        else
        begin
            drive = quot[7:0];
        end
        mag    = drive[7] ? 7'(-drive) : drive[6:0];
        scaled = {mag, 7'd0} + {2'd0, mag, 5'd0};
        out_word_next.drive      = drive;
        out_word_next.steer_left = !drive[7] && (drive != 8'sd0);
        out_word_next.duty_count = psd_pkg::DUTY_TOP - scaled;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= psd_pkg::GAIN_P_RESET;
            gain_i_reg  <= psd_pkg::GAIN_I_RESET;
            gain_d_reg  <= psd_pkg::GAIN_D_RESET;
            out_lim_reg <= psd_pkg::OUT_LIM_RESET;
        end
        else if (cfg_we)
        begin
            case (psd_pkg::cfg_index_t'(cfg_index))
                psd_pkg::CFG_GAIN_P:  gain_p_reg  <= cfg_data;
                psd_pkg::CFG_GAIN_I:  gain_i_reg  <= cfg_data;
                psd_pkg::CFG_GAIN_D:  gain_d_reg  <= cfg_data;
                psd_pkg::CFG_OUT_LIM: out_lim_reg <= cfg_data[6:0];
                default:              out_lim_reg <= out_lim_reg;
            endcase
        end
    end

    // control state and valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                error_sum_reg  <= error_sum_next;
                prev_error_reg <= err;
            end
            if (ready1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_err_reg   <= err;
            s1_sum_reg   <= error_sum_next;
            s1_deriv_reg <= deriv;
        end
        if (adv2)
        begin
            s2_p_reg <= p_next;
            s2_i_reg <= i_next;
            s2_d_reg <= d_next;
        end
        if (adv3)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `PSD_ASSERT_NOW(a_drive_range, out_valid_reg,
        (out_word_reg.drive <= 8'sd99) && (out_word_reg.drive >= -8'sd99))
    `PSD_ASSERT_NOW(a_dir_matches, out_valid_reg,
        out_word_reg.steer_left == (out_word_reg.drive > 8'sd0))
    `PSD_ASSERT_NEXT(a_accept_fills, accept, s1_valid_reg)
    `PSD_ASSERT_NEXT(a_result_moves, adv3, out_valid_reg)

endmodule

`default_nettype wire
